@@ design/bzr_pkg.sv @@
package bzr_pkg;

	// defaults for the top level parameters
	localparam int COORD_WIDTH_DEF = 24;
	localparam int T_FRAC_BITS_DEF = 16;

	// control point registers: p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = $clog2(NUM_REGS);

	// parameter queue between front and back
	localparam int QUEUE_DEPTH = 4;

endpackage

@@ design/bzr_front.sv @@
module bzr_front
	import bzr_pkg::*;
#(
	parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [T_FRAC_BITS:0] in_t,
	output logic                 q_valid,
	input  logic                 q_ready,
	output logic [T_FRAC_BITS:0] q_t
);

	localparam int TW  = T_FRAC_BITS + 1;
	localparam int PTW = $clog2(QUEUE_DEPTH);
	localparam int CNW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [TW-1:0]  T_ONE = TW'(1) << T_FRAC_BITS;
	localparam logic [CNW-1:0] FULL  = CNW'(QUEUE_DEPTH);

	logic [TW-1:0]  mem_q [QUEUE_DEPTH];
	logic [PTW-1:0] wr_ptr_q;
	logic [PTW-1:0] rd_ptr_q;
	logic [CNW-1:0] count_q;
	logic [TW-1:0]  t_clamp;
	logic           push;
	logic           pop;

	// anything above one is pinned to one, which lands on the end point
	assign t_clamp  = (in_t[T_FRAC_BITS] && (|in_t[T_FRAC_BITS-1:0])) ? T_ONE : in_t;
	assign in_ready = (count_q != FULL);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != '0);
	assign pop      = q_valid && q_ready;
	assign q_t      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= t_clamp;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("queue count above depth");

	a_head_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |-> (q_t <= T_ONE))
		else $error("queue head parameter above one");

	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CNW'(1)))
		else $error("queue count did not follow a lone push");
`endif

endmodule

@@ design/bzr_back.sv @@
module bzr_back
	import bzr_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [REG_IDX_W-1:0]          cfg_idx,
	input  logic [COORD_WIDTH-1:0]        cfg_data,
	input  logic                          q_valid,
	output logic                          q_ready,
	input  logic [T_FRAC_BITS:0]          q_t,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] point_x,
	output logic signed [COORD_WIDTH-1:0] point_y
);

	localparam int CW  = COORD_WIDTH;
	localparam int TF  = T_FRAC_BITS;
	localparam int TW  = TF + 1;
	localparam int WW  = 3 * TF + 1;          // Bernstein weight, at most 2^(3*TF)
	localparam int WL  = (WW + 1) / 2;        // weight split for the coordinate products
	localparam int WH  = WW - WL;
	localparam int PLW = CW + WL + 1;
	localparam int PHW = CW + WH + 1;
	localparam int SLW = PLW + 2;
	localparam int SHW = PHW + 2;
	localparam int AW  = CW + WW + 3;
	localparam logic [TW-1:0] T_ONE = TW'(1) << TF;
	localparam logic [AW-1:0] RND   = AW'(1) << (3 * TF - 1);

	logic signed [CW-1:0] coord_q [NUM_REGS];

	logic en;
	logic pop;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [TW-1:0]   u_c;
	logic [TW+1:0]   t3_c;
	logic [TW-1:0]   t_s1, u_s1;
	logic [2*TW-1:0] t2_s1, u2_s1;
	logic [2*TW+1:0] tu3_s1;

	logic [3*TW-1:0] w0_c, w3_c;
	logic [3*TW+1:0] w1_c, w2_c;
	logic [WW-1:0]   w_s2 [4];

	logic signed [PLW-1:0] pl_s3 [2][4];
	logic signed [PHW-1:0] ph_s3 [2][4];
	logic signed [SLW-1:0] sl_s4 [2];
	logic signed [SHW-1:0] sh_s4 [2];
	logic signed [AW-1:0]  acc_c [2];
	logic signed [CW-1:0]  point_s5 [2];

	// whole pipe advances together; the last stage is the output register
	assign en      = !v_s5 || out_ready;
	assign q_ready = en;
	assign pop     = q_valid && en;

	assign u_c  = T_ONE - q_t;
	assign t3_c = {1'b0, q_t, 1'b0} + (TW+2)'(q_t);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_REGS; r++) begin
				coord_q[r] <= '0;
			end
		end else if (cfg_we) begin
			coord_q[cfg_idx] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// s1: squares and 3*t*u
	always_ff @(posedge clk) begin
		if (en) begin
			t_s1   <= q_t;
			u_s1   <= u_c;
			t2_s1  <= (2*TW)'(q_t) * (2*TW)'(q_t);
			u2_s1  <= (2*TW)'(u_c) * (2*TW)'(u_c);
			tu3_s1 <= (2*TW+2)'(t3_c) * (2*TW+2)'(u_c);
		end
	end

	// s2: the four weights
	assign w0_c = (3*TW)'(u2_s1) * (3*TW)'(u_s1);
	assign w1_c = (3*TW+2)'(tu3_s1) * (3*TW+2)'(u_s1);
	assign w2_c = (3*TW+2)'(tu3_s1) * (3*TW+2)'(t_s1);
	assign w3_c = (3*TW)'(t2_s1) * (3*TW)'(t_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			w_s2[0] <= w0_c[WW-1:0];
			w_s2[1] <= w1_c[WW-1:0];
			w_s2[2] <= w2_c[WW-1:0];
			w_s2[3] <= w3_c[WW-1:0];
		end
	end

	// s3: coordinate times low and high halves of each weight
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 2; a++) begin
				for (int i = 0; i < 4; i++) begin
					pl_s3[a][i] <= PLW'(coord_q[2*i+a])
						* PLW'($signed({1'b0, w_s2[i][WL-1:0]}));
					ph_s3[a][i] <= PHW'(coord_q[2*i+a])
						* PHW'($signed({1'b0, w_s2[i][WW-1:WL]}));
				end
			end
		end
	end

	// s4: sum the four terms per half
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 2; a++) begin
				sl_s4[a] <= SLW'(pl_s3[a][0]) + SLW'(pl_s3[a][1])
					+ SLW'(pl_s3[a][2]) + SLW'(pl_s3[a][3]);
				sh_s4[a] <= SHW'(ph_s3[a][0]) + SHW'(ph_s3[a][1])
					+ SHW'(ph_s3[a][2]) + SHW'(ph_s3[a][3]);
			end
		end
	end

	// s5: recombine, round half up, drop the weight fraction
	always_comb begin
		for (int a = 0; a < 2; a++) begin
			acc_c[a] = (AW'(sh_s4[a]) <<< WL) + AW'(sl_s4[a]) + RND;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 2; a++) begin
				point_s5[a] <= acc_c[a][3*TF +: CW];
			end
		end
	end

	assign out_valid = v_s5;
	assign point_x   = point_s5[0];
	assign point_y   = point_s5[1];

`ifndef NO_ASSERTIONS
	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable({v_s1, v_s2, v_s3, v_s4, v_s5}))
		else $error("pipe moved while stalled");

	a_pop_enters: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> v_s1)
		else $error("popped parameter lost at first stage");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !out_ready) |=> (v_s5 && $stable(point_s5[0]) && $stable(point_s5[1])))
		else $error("pending result changed under stall");
`endif

endmodule

@@ design/cubic_bezier_point_eval_core.sv @@
// Channel   Dir  Fields (lsb first)                       Transfer
// s_axis    in   tdata: t_param, zero pad                  s_tvalid & s_tready
// m_axis    out  tdata: point_x, point_y, zero pad         m_tvalid & m_tready
// cfg       in   cfg_idx 0..7 = p0_x p0_y p1_x p1_y ...    cfg_we
//
// One point per cycle sustained while m_tready stays high.
// A parameter passes the queue, then the pipe stages, before m_tvalid rises for it.
// arst_n clears the queue, the pipe valids and all control points to zero.
// A stall on m_tready freezes the pipe; input keeps flowing until the queue fills.
module cubic_bezier_point_eval_core
	import bzr_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [REG_IDX_W-1:0]                   cfg_idx,
	input  logic [COORD_WIDTH-1:0]                 cfg_data,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((T_FRAC_BITS+8)/8)*8-1:0]       s_tdata,   // t_param
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [((2*COORD_WIDTH+7)/8)*8-1:0]     m_tdata    // point_x, point_y
);

	localparam int MDW = ((2 * COORD_WIDTH + 7) / 8) * 8;

	logic                          q_valid;
	logic                          q_ready;
	logic [T_FRAC_BITS:0]          q_t;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;

	bzr_front #(
		.T_FRAC_BITS(T_FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_t     (s_tdata[T_FRAC_BITS:0]),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_t      (q_t)
	);

	bzr_back #(
		.COORD_WIDTH(COORD_WIDTH),
		.T_FRAC_BITS(T_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_t       (q_t),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.point_x   (point_x),
		.point_y   (point_y)
	);

	assign m_tdata = MDW'({point_y, point_x});

endmodule
